// ===== rtl/gkcm_pkg.sv =====
// shared types, constants and the threshold function for the gyro cursor filter
// no dependencies; imported by every module of the block
`default_nettype none

package gkcm_pkg;

  localparam int DATA_W     = 32;  // rates, biases, estimates, covariance
  localparam int NOISE_W    = 30;  // process and measurement variance
  localparam int PP_W       = 33;  // covariance plus process noise
  localparam int DEN_W      = 34;  // gain denominator
  localparam int GAIN_W     = 31;  // gain, at most one in q1.30
  localparam int MAG_W      = 33;  // magnitude of the bias corrected rate
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 32;
  localparam int MUL_HALF_W = 16;
  localparam int PART_W     = MUL_A_W + MUL_HALF_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int STEP_OUT_W = 7;
  localparam int MOVE_W     = 8;
  localparam int THR_W      = 36;
  localparam int BIG_W      = 480;
  localparam int Q_SHIFT    = 30;
  localparam int CFG_IDX_W  = 2;

  localparam int unsigned DATA_FRAC_BITS_DEF = 16;
  localparam int unsigned MAX_STEP_DEF       = 127;

  localparam logic [GAIN_W-1:0]  ONE_Q30    = GAIN_W'(1) << Q_SHIFT;
  localparam logic [DATA_W-1:0]  COV_RST    = DATA_W'(ONE_Q30);
  localparam logic [NOISE_W-1:0] PNOISE_RST = NOISE_W'(10737);
  localparam logic [NOISE_W-1:0] MNOISE_RST = NOISE_W'(10737418);

  // curve: |u| >= scale * n^(den/num), tested as |u|^num >= scale^num * n^den
  localparam int CURVE_SCALE   = 20;
  localparam int CURVE_NUM_EXP = 13;
  localparam int CURVE_DEN_EXP = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS_Z,
    CFG_BIAS_Y,
    CFG_PNOISE,
    CFG_MNOISE
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COV,
    ST_EST_Z,
    ST_EST_Y,
    ST_STEP_Z,
    ST_STEP_Y,
    ST_OUT
  } top_st_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_st_t;

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_LO,
    MP_HI,
    MP_SUM,
    MP_DONE
  } mul_ph_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_RUN,
    SP_DONE
  } stp_st_t;

  typedef struct packed {
    logic              start;
    logic [PP_W-1:0]   pp;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] k;
  } div_rsp_t;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [PROD_W-1:0]   prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  mag;
  } stp_req_t;

  typedef struct packed {
    logic                   done;
    logic [STEP_OUT_W-1:0]  step;
  } stp_rsp_t;

  // smallest a with a^13 >= (20 * 2^frac)^13 * n^10, evaluated at elaboration
  function automatic logic [THR_W-1:0] thr_calc(input int unsigned n, input int unsigned frac);
    logic [BIG_W-1:0] target;
    logic [BIG_W-1:0] kq;
    logic [BIG_W-1:0] pw;
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    logic [THR_W-1:0] mid;
    target = BIG_W'(1);
    kq = BIG_W'(CURVE_SCALE) << frac;
    for (int i = 0; i < CURVE_NUM_EXP; i++) target = target * kq;
    for (int i = 0; i < CURVE_DEN_EXP; i++) target = target * BIG_W'(n);
    lo = '0;
    hi = '1;
    for (int s = 0; s <= THR_W; s++) begin
      mid = lo + ((hi - lo) >> 1);
      pw = BIG_W'(1);
      for (int i = 0; i < CURVE_NUM_EXP; i++) pw = pw * BIG_W'(mid);
      if (lo < hi) begin
        if (pw >= target) hi = mid;
        else lo = mid + 1'b1;
      end
    end
    return lo;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gkcm_div.sv =====
// restoring divider for the kalman gain, one quotient bit per cycle
// depends on gkcm_pkg
`default_nettype none

module gkcm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gkcm_pkg::div_req_t  req,
  output gkcm_pkg::div_rsp_t  rsp
);
  import gkcm_pkg::*;

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(GAIN_W);

  div_st_t            state_r, state_nxt;
  logic [REM_W-1:0]   rem_r;
  logic [DEN_W-1:0]   den_r;
  logic [GAIN_W-1:0]  quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               zero_r;
  logic               ge;
  logic [REM_W-1:0]   diff;

  assign ge   = rem_r >= REM_W'(den_r);
  assign diff = rem_r - REM_W'(den_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (req.start) state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == '0) state_nxt = DV_DONE;
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == DV_DONE);
    // zero denominator gives zero gain
    rsp.k    = zero_r ? '0 : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && req.start) begin
      // first compare yields the integer bit, since pp never exceeds den
      rem_r  <= REM_W'(req.pp);
      den_r  <= req.den;
      zero_r <= (req.den == '0);
      quo_r  <= '0;
      cnt_r  <= CNT_W'(GAIN_W - 1);
    end else if (state_r == DV_RUN) begin
      rem_r <= (ge ? diff : rem_r) << 1;
      quo_r <= {quo_r[GAIN_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gkcm_mul.sv =====
// shared signed multiplier: 34 x 32 bits as two 16-bit halves, summed over cycles
// depends on gkcm_pkg
`default_nettype none

module gkcm_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  gkcm_pkg::mul_req_t  req,
  output gkcm_pkg::mul_rsp_t  rsp
);
  import gkcm_pkg::*;

  mul_ph_t                        ph_r, ph_nxt;
  logic signed [MUL_A_W-1:0]      a_r;
  logic        [MUL_B_W-1:0]      b_r;
  logic signed [PART_W-1:0]       part_r;
  logic signed [PROD_W-1:0]       acc_r;
  logic signed [MUL_HALF_W:0]     half;
  logic signed [PART_W-1:0]       part_c;

  // low half unsigned, high half carries the sign
  assign half = (ph_r == MP_LO) ? $signed({1'b0, b_r[MUL_HALF_W-1:0]})
                                : $signed({b_r[MUL_B_W-1], b_r[MUL_B_W-1:MUL_HALF_W]});
  assign part_c = a_r * half;

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      MP_IDLE: if (req.start) ph_nxt = MP_LO;
      MP_LO:   ph_nxt = MP_HI;
      MP_HI:   ph_nxt = MP_SUM;
      MP_SUM:  ph_nxt = MP_DONE;
      // the next pass may start while this product is being taken
      MP_DONE: ph_nxt = req.start ? MP_LO : MP_IDLE;
      default: ph_nxt = MP_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (ph_r == MP_DONE);
    rsp.prod = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= MP_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((ph_r == MP_IDLE || ph_r == MP_DONE) && req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    case (ph_r)
      MP_LO: part_r <= part_c;
      MP_HI: begin
        acc_r  <= PROD_W'(part_r);
        part_r <= part_c;
      end
      MP_SUM: acc_r <= acc_r + (PROD_W'(part_r) <<< MUL_HALF_W);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gkcm_step.sv =====
// cursor step search: one step bit per cycle against a threshold rom
// depends on gkcm_pkg (thr_calc builds the rom at elaboration)
`default_nettype none

module gkcm_step #(
  parameter int unsigned DATA_FRAC_BITS = gkcm_pkg::DATA_FRAC_BITS_DEF,
  parameter int unsigned MAX_STEP       = gkcm_pkg::MAX_STEP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gkcm_pkg::stp_req_t  req,
  output gkcm_pkg::stp_rsp_t  rsp
);
  import gkcm_pkg::*;

  localparam int STEP_W = (MAX_STEP > 1) ? $clog2(MAX_STEP + 1) : 1;
  localparam int TAB_N  = 1 << STEP_W;

  stp_st_t              state_r, state_nxt;
  logic [MAG_W-1:0]     mag_r;
  logic [STEP_W-1:0]    step_r;
  logic [STEP_W-1:0]    mask_r;
  logic [STEP_W-1:0]    cand;
  logic                 hit;
  logic                 load;
  logic [THR_W-1:0]     thr_tab [TAB_N];

  // entries past the top step can never be reached by any magnitude
  for (genvar g = 0; g < TAB_N; g++) begin : g_thr
    if (g == 0 || g > MAX_STEP) begin : g_none
      assign thr_tab[g] = '1;
    end else begin : g_val
      localparam logic [THR_W-1:0] THR = thr_calc(g, DATA_FRAC_BITS);
      assign thr_tab[g] = THR;
    end
  end

  assign cand = step_r | mask_r;
  assign hit  = THR_W'(mag_r) >= thr_tab[cand];
  // a new search may start straight from done
  assign load = (state_r == SP_IDLE || state_r == SP_DONE) && req.start;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SP_IDLE: if (req.start) state_nxt = SP_RUN;
      SP_RUN:  if (mask_r[0]) state_nxt = SP_DONE;
      SP_DONE: state_nxt = req.start ? SP_RUN : SP_IDLE;
      default: state_nxt = SP_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == SP_DONE);
    rsp.step = STEP_OUT_W'(step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r  <= req.mag;
      step_r <= '0;
      mask_r <= STEP_W'(1) << (STEP_W - 1);
    end else if (state_r == SP_RUN) begin
      if (hit) step_r <= cand;
      mask_r <= mask_r >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gyro_kalman_cursor_motion.sv =====
// flow: items are taken only in idle, one at a time; in_stall is low again the cycle after
// the result is loaded, while that result may still wait in the output register
// datapath: 31-step gain divider, three multiplier passes, two bit-serial step searches
// reset: synchronous rst_n clears the sequencer, zeroes both estimates and biases, sets the
// covariance to one and the noise registers to their defaults
`default_nettype none

module gyro_kalman_cursor_motion #(
  parameter int unsigned DATA_FRAC_BITS = gkcm_pkg::DATA_FRAC_BITS_DEF,
  parameter int unsigned MAX_STEP       = gkcm_pkg::MAX_STEP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [gkcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gkcm_pkg::DATA_W-1:0]           cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gkcm_pkg::DATA_W-1:0]    in_gyro_z,
  input  logic signed [gkcm_pkg::DATA_W-1:0]    in_gyro_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gkcm_pkg::MOVE_W-1:0]    out_move_x,
  output logic signed [gkcm_pkg::MOVE_W-1:0]    out_move_y
);
  import gkcm_pkg::*;

  top_st_t                     state_r, state_nxt;

  logic signed [DATA_W-1:0]    bias_z_r, bias_y_r;
  logic [NOISE_W-1:0]          pnoise_r, mnoise_r;
  logic signed [DATA_W-1:0]    est_z_r, est_y_r;
  logic [DATA_W-1:0]           cov_r;

  logic signed [DATA_W-1:0]    mz_r, my_r;
  logic [PP_W-1:0]             pp_r;
  logic [GAIN_W-1:0]           k_r;
  logic [STEP_OUT_W-1:0]       step_z_r, step_y_r;
  logic                        out_valid_r;
  logic signed [MOVE_W-1:0]    out_move_x_r, out_move_y_r;

  div_req_t                    div_req;
  div_rsp_t                    div_rsp;
  mul_req_t                    mul_req;
  mul_rsp_t                    mul_rsp;
  stp_req_t                    stp_req;
  stp_rsp_t                    stp_rsp;

  logic                        accept;
  logic                        load_out;
  logic [PP_W-1:0]             pp_c;
  logic [DEN_W-1:0]            den_c;
  logic signed [MUL_A_W-1:0]   diff_z, diff_y;
  logic signed [MAG_W-1:0]     u_z, u_y;
  logic [MAG_W-1:0]            mag_z, mag_y;
  logic                        pos_z, pos_y;
  logic [DATA_W-1:0]           prod_q;
  logic [MOVE_W-1:0]           move_x_c, move_y_c;

  gkcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gkcm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  gkcm_step #(
    .DATA_FRAC_BITS (DATA_FRAC_BITS),
    .MAX_STEP       (MAX_STEP)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stp_req),
    .rsp   (stp_rsp)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign load_out   = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign out_valid  = out_valid_r;
  assign out_move_x = out_move_x_r;
  assign out_move_y = out_move_y_r;

  assign pp_c  = PP_W'(cov_r) + PP_W'(pnoise_r);
  assign den_c = DEN_W'(pp_c) + DEN_W'(mnoise_r);

  assign diff_z = MUL_A_W'(mz_r) - MUL_A_W'(est_z_r);
  assign diff_y = MUL_A_W'(my_r) - MUL_A_W'(est_y_r);

  // product >> 30 floors toward minus infinity; the low 32 bits are all that is kept
  assign prod_q = mul_rsp.prod[Q_SHIFT+DATA_W-1:Q_SHIFT];

  assign u_z   = MAG_W'(est_z_r) - MAG_W'(bias_z_r);
  assign u_y   = MAG_W'(est_y_r) - MAG_W'(bias_y_r);
  assign mag_z = u_z[MAG_W-1] ? MAG_W'(-u_z) : MAG_W'(u_z);
  assign mag_y = u_y[MAG_W-1] ? MAG_W'(-u_y) : MAG_W'(u_y);
  assign pos_z = !u_z[MAG_W-1] && (u_z != '0);
  assign pos_y = !u_y[MAG_W-1] && (u_y != '0);

  // cursor moves against the rate
  assign move_x_c = pos_z ? (MOVE_W'(0) - MOVE_W'(step_z_r)) : MOVE_W'(step_z_r);
  assign move_y_c = pos_y ? (MOVE_W'(0) - MOVE_W'(step_y_r)) : MOVE_W'(step_y_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_DIV;
      ST_DIV:    if (div_rsp.done) state_nxt = ST_COV;
      ST_COV:    if (mul_rsp.done) state_nxt = ST_EST_Z;
      ST_EST_Z:  if (mul_rsp.done) state_nxt = ST_EST_Y;
      ST_EST_Y:  if (mul_rsp.done) state_nxt = ST_STEP_Z;
      ST_STEP_Z: if (stp_rsp.done) state_nxt = ST_STEP_Y;
      ST_STEP_Y: if (stp_rsp.done) state_nxt = ST_OUT;
      ST_OUT:    if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_req.start = accept;
    div_req.pp    = pp_c;
    div_req.den   = den_c;

    mul_req.start = 1'b0;
    mul_req.a     = diff_z;
    mul_req.b     = $signed({1'b0, k_r});

    stp_req.start = 1'b0;
    stp_req.mag   = mag_z;

    unique case (state_r)
      ST_DIV: begin
        mul_req.start = div_rsp.done;
        mul_req.a     = $signed({1'b0, pp_r});
        mul_req.b     = $signed({1'b0, ONE_Q30 - div_rsp.k});
      end
      ST_COV: begin
        mul_req.start = mul_rsp.done;
      end
      ST_EST_Z: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = diff_y;
      end
      ST_EST_Y: begin
        stp_req.start = mul_rsp.done;
      end
      ST_STEP_Z: begin
        stp_req.start = stp_rsp.done;
        stp_req.mag   = mag_y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bias_z_r    <= '0;
      bias_y_r    <= '0;
      pnoise_r    <= PNOISE_RST;
      mnoise_r    <= MNOISE_RST;
      est_z_r     <= '0;
      est_y_r     <= '0;
      cov_r       <= COV_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out || (out_valid_r && out_stall);
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_BIAS_Z: bias_z_r <= cfg_wdata;
          CFG_BIAS_Y: bias_y_r <= cfg_wdata;
          CFG_PNOISE: pnoise_r <= cfg_wdata[NOISE_W-1:0];
          CFG_MNOISE: mnoise_r <= cfg_wdata[NOISE_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_COV && mul_rsp.done) cov_r <= prod_q;
      if (state_r == ST_EST_Z && mul_rsp.done) est_z_r <= est_z_r + prod_q;
      if (state_r == ST_EST_Y && mul_rsp.done) est_y_r <= est_y_r + prod_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mz_r <= in_gyro_z;
      my_r <= in_gyro_y;
      pp_r <= pp_c;
    end
    if (state_r == ST_DIV && div_rsp.done) k_r <= div_rsp.k;
    if (state_r == ST_STEP_Z && stp_rsp.done) step_z_r <= stp_rsp.step;
    if (state_r == ST_STEP_Y && stp_rsp.done) step_y_r <= stp_rsp.step;
    if (load_out) begin
      out_move_x_r <= move_x_c;
      out_move_y_r <= move_y_c;
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_rsp.done) |-> (div_rsp.k <= ONE_Q30))
    else $error("kalman gain above one");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COV && mul_rsp.done) |=> ({1'b0, cov_r} <= pp_r))
    else $error("covariance grew in the update");

  a_move_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_move_x[MOVE_W-1] ? (MOVE_W'(0) - MOVE_W'(out_move_x))
                                         : MOVE_W'(out_move_x)) <= MOVE_W'(MAX_STEP)))
    else $error("x step out of range");

  a_move_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_move_y[MOVE_W-1] ? (MOVE_W'(0) - MOVE_W'(out_move_y))
                                         : MOVE_W'(out_move_y)) <= MOVE_W'(MAX_STEP)))
    else $error("y step out of range");

endmodule

`default_nettype wire
